// File: rtl/dlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlf_pkg
// Character codes, fixed-point constants and shared types of the
// decimal literal to fixed-point converter.
// ----------------------------------------------------------------------------
package dlf_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SUFFIX = 8'h66;

  // fraction accumulator and digit weight are Q0.32
  localparam int unsigned QW = 32;
  localparam logic [QW-1:0] TENTH_Q32 = 32'h1999_999A;

  typedef struct packed {
    logic negative;
    logic sat_seen;
    logic bad_seen;
  } flags_t;

endpackage

// File: rtl/dlf_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlf_char_if
// Character channel: one ASCII character per item, with a last marker.
// ----------------------------------------------------------------------------
interface dlf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: rtl/dlf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlf_result_if
// Result channel: signed fixed-point value with saturation and bad flags.
// ----------------------------------------------------------------------------
interface dlf_result_if #(
  parameter int VAL_W = 40
);
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    saturated;
  logic                    bad_char;

  modport source (output valid, output value, output saturated, output bad_char,
                  input ready);
  modport sink   (input valid, input value, input saturated, input bad_char,
                  output ready);
endinterface

// File: rtl/dlf_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlf_accum
// Input register, per-character accumulator update and the register that
// hands a finished literal to the output stage.
// ----------------------------------------------------------------------------
module dlf_accum #(
  parameter int INT_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dlf_char_if.sink                  char_i,
  output logic                      fin_valid_o,
  input  logic                      fin_ready_i,
  output logic [INT_BITS-2:0]       fin_int_o,
  output logic [dlf_pkg::QW-1:0]    fin_frac_o,
  output dlf_pkg::flags_t           fin_flags_o
);
  import dlf_pkg::*;

  localparam int IMAG_W = INT_BITS - 1;

  typedef enum logic [1:0] {
    PH_START,
    PH_INT,
    PH_FRAC,
    PH_SUFFIX
  } phase_e;

  logic              in_v_q, in_v_d;
  logic [7:0]        ch_q;
  logic              last_q;

  logic [IMAG_W-1:0] int_q, int_d, int_u;
  logic [QW-1:0]     frac_q, frac_d, frac_u;
  logic [QW-1:0]     scale_q, scale_d, scale_u;
  phase_e            phase_q, phase_d, phase_u;
  flags_t            flags_q, flags_d, flags_u;

  logic              fin_v_q, fin_v_d;
  logic [IMAG_W-1:0] fin_int_q;
  logic [QW-1:0]     fin_frac_q;
  flags_t            fin_flags_q;

  logic              fin_free, consume, in_take;
  logic              is_digit;
  logic [3:0]        digit;
  logic [IMAG_W+3:0] int_x10;
  logic              int_ovf;
  logic [QW+3:0]     frac_prod;
  logic [QW+4:0]     frac_sum;
  logic              frac_ovf;
  logic [2*QW-1:0]   scale_prod;
  logic [QW-1:0]     scale_nx;

  assign fin_free     = !fin_v_q || fin_ready_i;
  assign consume      = in_v_q && (!last_q || fin_free);
  assign char_i.ready = !in_v_q || consume;
  assign in_take      = char_i.valid && char_i.ready;

  assign is_digit   = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign digit      = 4'(ch_q - CH_ZERO);
  assign int_x10    = ((IMAG_W+4)'(int_q) << 3) + ((IMAG_W+4)'(int_q) << 1)
                      + (IMAG_W+4)'(digit);
  assign int_ovf    = |int_x10[IMAG_W+3:IMAG_W];
  assign frac_prod  = (QW+4)'(digit) * (QW+4)'(scale_q);
  assign frac_sum   = (QW+5)'(frac_q) + (QW+5)'(frac_prod);
  assign frac_ovf   = |frac_sum[QW+4:QW];
  assign scale_prod = (2*QW)'(scale_q) * (2*QW)'(TENTH_Q32);
  assign scale_nx   = scale_prod[2*QW-1:QW] + QW'(scale_prod[QW-1]);

  always_comb begin
    int_u   = int_q;
    frac_u  = frac_q;
    scale_u = scale_q;
    phase_u = phase_q;
    flags_u = flags_q;
    if (is_digit) begin
      unique case (phase_q)
        PH_START, PH_INT: begin
          if (int_ovf) begin
            int_u            = {IMAG_W{1'b1}};
            flags_u.sat_seen = 1'b1;
          end else begin
            int_u = int_x10[IMAG_W-1:0];
          end
          phase_u = PH_INT;
        end
        PH_FRAC: begin
          frac_u  = frac_ovf ? {QW{1'b1}} : frac_sum[QW-1:0];
          scale_u = scale_nx;
        end
        default: flags_u.bad_seen = 1'b1;
      endcase
    end else if (ch_q == CH_MINUS) begin
      if (phase_q == PH_START) begin
        flags_u.negative = 1'b1;
        phase_u          = PH_INT;
      end else begin
        flags_u.bad_seen = 1'b1;
      end
    end else if (ch_q == CH_POINT) begin
      if (phase_q == PH_START || phase_q == PH_INT) phase_u = PH_FRAC;
      else flags_u.bad_seen = 1'b1;
    end else if (ch_q == CH_SUFFIX) begin
      if (phase_q != PH_SUFFIX) phase_u = PH_SUFFIX;
      else flags_u.bad_seen = 1'b1;
    end else begin
      flags_u.bad_seen = 1'b1;
    end
  end

  always_comb begin
    int_d   = int_q;
    frac_d  = frac_q;
    scale_d = scale_q;
    phase_d = phase_q;
    flags_d = flags_q;
    fin_v_d = fin_v_q && !fin_ready_i;
    in_v_d  = in_take ? 1'b1 : (consume ? 1'b0 : in_v_q);
    if (consume) begin
      if (last_q) begin
        int_d   = '0;
        frac_d  = '0;
        scale_d = TENTH_Q32;
        phase_d = PH_START;
        flags_d = '0;
        fin_v_d = 1'b1;
      end else begin
        int_d   = int_u;
        frac_d  = frac_u;
        scale_d = scale_u;
        phase_d = phase_u;
        flags_d = flags_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      scale_q <= TENTH_Q32;
      phase_q <= PH_START;
      flags_q <= '0;
      fin_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      scale_q <= scale_d;
      phase_q <= phase_d;
      flags_q <= flags_d;
      fin_v_q <= fin_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q   <= char_i.ch;
      last_q <= char_i.last;
    end
    if (consume && last_q) begin
      fin_int_q   <= int_u;
      fin_frac_q  <= frac_u;
      fin_flags_q <= flags_u;
    end
  end

  assign fin_valid_o = fin_v_q;
  assign fin_int_o   = fin_int_q;
  assign fin_frac_o  = fin_frac_q;
  assign fin_flags_o = fin_flags_q;

endmodule

// File: rtl/dlf_final.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlf_final
// Round the fraction, merge with the integer part, clamp, apply the sign
// and hold the result in the output register.
// ----------------------------------------------------------------------------
module dlf_final #(
  parameter int INT_BITS  = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fin_valid_i,
  output logic                   fin_ready_o,
  input  logic [INT_BITS-2:0]    fin_int_i,
  input  logic [dlf_pkg::QW-1:0] fin_frac_i,
  input  dlf_pkg::flags_t        fin_flags_i,
  dlf_result_if.source           result_o
);
  import dlf_pkg::*;

  localparam int TOT_W = INT_BITS + FRAC_BITS;

  logic             out_v_q;
  logic [TOT_W-1:0] value_q;
  logic             sat_q;
  logic             bad_q;

  logic [QW:0]        rnd;
  logic [FRAC_BITS:0] fq;
  logic [TOT_W-1:0]   mag, mag_c, val;
  logic               mag_ovf, take;

  assign fin_ready_o = !out_v_q || result_o.ready;
  assign take        = fin_valid_i && fin_ready_o;

  assign rnd     = (QW+1)'(fin_frac_i) + ((QW+1)'(1) << (QW - 1 - FRAC_BITS));
  assign fq      = rnd[QW:QW-FRAC_BITS];
  assign mag     = (TOT_W'(fin_int_i) << FRAC_BITS) + TOT_W'(fq);
  assign mag_ovf = mag[TOT_W-1];
  assign mag_c   = mag_ovf ? {1'b0, {(TOT_W-1){1'b1}}} : mag;
  assign val     = fin_flags_i.negative ? (~mag_c + TOT_W'(1)) : mag_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fin_ready_o) begin
      out_v_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      value_q <= val;
      sat_q   <= fin_flags_i.sat_seen || mag_ovf;
      bad_q   <= fin_flags_i.bad_seen;
    end
  end

  assign result_o.valid     = out_v_q;
  assign result_o.value     = $signed(value_q);
  assign result_o.saturated = sat_q;
  assign result_o.bad_char  = bad_q;

endmodule

// File: rtl/decimal_literal_to_fixed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_literal_to_fixed
// Decimal literal (ASCII, one character per item) to signed fixed point.
// ----------------------------------------------------------------------------
// Takes one character per cycle when not stalled: an optional '-', integer
// digits, an optional '.', fraction digits and an optional trailing 'f'.
// Each character passes an input register, updates the accumulators in the
// next cycle, and the item marked last leaves its totals in a hand-off
// register; the output register shows the signed Q(INT_BITS).(FRAC_BITS)
// value once the hand-off register has passed it on. The accumulator
// update (a constant multiply for the next digit weight) sets the one
// character per cycle figure; stalls on the result side only hold the input
// once both the hand-off and output registers are full and another last
// character waits. No start-up pass after reset.
module decimal_literal_to_fixed #(
  parameter int INT_BITS  = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dlf_char_if.sink     char_i,
  dlf_result_if.source result_o
);
  import dlf_pkg::*;

  logic                fin_valid;
  logic                fin_ready;
  logic [INT_BITS-2:0] fin_int;
  logic [QW-1:0]       fin_frac;
  flags_t              fin_flags;

  dlf_accum #(
    .INT_BITS (INT_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .fin_valid_o (fin_valid),
    .fin_ready_i (fin_ready),
    .fin_int_o   (fin_int),
    .fin_frac_o  (fin_frac),
    .fin_flags_o (fin_flags)
  );

  dlf_final #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_valid_i (fin_valid),
    .fin_ready_o (fin_ready),
    .fin_int_i   (fin_int),
    .fin_frac_i  (fin_frac),
    .fin_flags_i (fin_flags),
    .result_o    (result_o)
  );

endmodule

// File: rtl/dlf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlf_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module dlf_checker #(
  parameter int VAL_W = 40
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [VAL_W-1:0] out_value_i,
  input logic             out_sat_i,
  input logic             out_bad_i
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_value_i) && $stable(out_sat_i) && $stable(out_bad_i))
    else $error("result item changed while stalled");

  a_in_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input held off with empty output register");

  a_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_value_i != {1'b1, {(VAL_W-1){1'b0}}})
    else $error("magnitude not clamped to symmetric range");

endmodule

bind decimal_literal_to_fixed dlf_checker #(
  .VAL_W (INT_BITS + FRAC_BITS)
) u_dlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (char_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_value_i (result_o.value),
  .out_sat_i   (result_o.saturated),
  .out_bad_i   (result_o.bad_char)
);
